// ----- hdl/tmpg_pkg.sv -----
package tmpg_pkg;

    // Field widths
    localparam int IDX_W      = 8;
    localparam int RADIUS_W   = 14;
    localparam int SEG_W      = 9;
    localparam int ANGLE_BITS = 16;
    localparam int TWIST_W    = 9;
    localparam int COORD_W    = 16;
    localparam int CORNER_W   = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [SEG_W-1:0] MAX_SEGMENTS = 9'd256;
    localparam logic [SEG_W-1:0] MIN_MAJOR    = 9'd3;
    localparam logic [SEG_W-1:0] MIN_MINOR    = 9'd2;

    // Divider geometry: ring/step sum numerator, then fraction bits of the angle
    localparam int NSUM_W    = 18;
    localparam int TOTAL_W   = 17;
    localparam int REM_W     = 17;
    localparam int DIV_STEPS = NSUM_W + ANGLE_BITS;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MAJOR_RADIUS   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MINOR_RADIUS   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAJOR_SEGMENTS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MINOR_SEGMENTS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_START_ANGLE    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TWIST          = 3'd5;

    // Sine lanes
    localparam int N_LANES    = 4;
    localparam int LANE_SIN_T = 0;
    localparam int LANE_COS_T = 1;
    localparam int LANE_SIN_P = 2;
    localparam int LANE_COS_P = 3;

    // Quarter-wave polynomial, Q30
    localparam int FRAC_W = ANGLE_BITS - 2;
    localparam int X_W    = FRAC_W + 1;
    localparam logic [X_W-1:0] QUARTER = X_W'(1 << FRAC_W);
    localparam logic [ANGLE_BITS-1:0] QUARTER_TURN = ANGLE_BITS'(1 << FRAC_W);
    localparam logic [30:0] Q30_ONE  = 31'h4000_0000;
    localparam logic [30:0] Q30_HALF = 31'h2000_0000;
    localparam logic [30:0] K1 = 31'd1686629713;
    localparam logic [30:0] K3 = 31'd693598666;
    localparam logic [30:0] K5 = 31'd85569306;
    localparam logic [30:0] K7 = 31'd5026995;
    localparam logic [30:0] K9 = 31'd172272;
    localparam int POLY_STEPS = 4;
    localparam logic [30:0] POLY_C [POLY_STEPS] = '{K7, K5, K3, K1};

    typedef struct packed {
        logic [REM_W-1:0]      rem;
        logic [ANGLE_BITS-1:0] quo;
    } t_div_lane;

    typedef struct packed {
        logic [IDX_W-1:0]    ring;
        logic [NSUM_W-1:0]   nsum;
        logic [CORNER_W-1:0] a;
        logic [CORNER_W-1:0] b;
        logic [CORNER_W-1:0] c;
        logic [CORNER_W-1:0] d;
        logic                ge_b;
        logic                ge_c;
        logic                ge_d;
        logic [REM_W-1:0]    mb;
        logic [REM_W-1:0]    mc;
        logic [REM_W-1:0]    md;
        logic                err;
        t_div_lane           phi;
        t_div_lane           theta;
        t_div_lane           qb;
        t_div_lane           qc;
        t_div_lane           qd;
    } t_dv_item;

    typedef struct packed {
        logic           neg;
        logic [X_W-1:0] x;
        logic [30:0]    x2;
        logic [30:0]    t;
        logic [30:0]    mag;
    } t_sin_lane;

    typedef struct packed {
        t_sin_lane [N_LANES-1:0] lane;
        logic [CORNER_W-1:0]     a;
        logic [CORNER_W-1:0]     b;
        logic [CORNER_W-1:0]     c;
        logic [CORNER_W-1:0]     d;
        logic                    err;
    } t_tr_item;

    typedef struct packed {
        logic signed [16:0]  r;
        logic signed [16:0]  y;
        logic [30:0]         mag_sp;
        logic [30:0]         mag_cp;
        logic                neg_sp;
        logic                neg_cp;
        logic [CORNER_W-1:0] a;
        logic [CORNER_W-1:0] b;
        logic [CORNER_W-1:0] c;
        logic [CORNER_W-1:0] d;
        logic                err;
    } t_m1_item;

    function automatic logic [SEG_W-1:0] clamp_count(
        input logic [SEG_W-1:0] v,
        input logic [SEG_W-1:0] lo
    );
        if (v < lo) begin
            return lo;
        end else if (v > MAX_SEGMENTS) begin
            return MAX_SEGMENTS;
        end
        return v;
    endfunction

    // One restoring division step
    function automatic t_div_lane div_step(
        input t_div_lane        ln,
        input logic             dbit,
        input logic [TOTAL_W-1:0] dvs
    );
        logic [REM_W:0] sh;
        t_div_lane      res;
        sh = {ln.rem, dbit};
        if (sh >= {1'b0, dvs}) begin
            res.rem = REM_W'(sh - {1'b0, dvs});
            res.quo = {ln.quo[ANGLE_BITS-2:0], 1'b1};
        end else begin
            res.rem = REM_W'(sh);
            res.quo = {ln.quo[ANGLE_BITS-2:0], 1'b0};
        end
        return res;
    endfunction

    // One Horner step of the polynomial: c - x2*t/2^30
    function automatic logic [30:0] poly_step(
        input logic [30:0] x2,
        input logic [30:0] t,
        input logic [30:0] c
    );
        logic [61:0] p;
        p = 62'(x2) * 62'(t);
        return 31'(c - 31'(p >> 30));
    endfunction

    // Magnitude product with a Q30 value, rounded half up on the magnitude
    function automatic logic [16:0] mul_round(
        input logic [15:0] a,
        input logic [30:0] b
    );
        logic [46:0] p;
        p = 47'(a) * 47'(b) + 47'(Q30_HALF);
        return 17'(p >> 30);
    endfunction

    function automatic logic [COORD_W-1:0] sat_coord(input logic signed [17:0] v);
        if (v > 18'sd32767) begin
            return 16'h7FFF;
        end else if (v < -18'sd32768) begin
            return 16'h8000;
        end
        return v[COORD_W-1:0];
    endfunction

endpackage

// ----- hdl/torus_mesh_point_generator.sv -----
// Channel     | Direction | Handshake                  | Word
// ------------+-----------+----------------------------+------------------------------------
// request     | in        | start, busy (always low)   | i_ring_index, i_step_index
// result      | out       | o_out_strobe, one cycle    | o_pos_x/y/z, o_corner_a..d, o_index_error
// config      | in        | i_cfg_valid, o_cfg_ready   | i_cfg_index, i_cfg_data
//
// One request enters every cycle; its result reaches the ports through the capture and load
// registers, the 34-step restoring dividers (angle fractions and corner wrap), the
// six-stage quarter-wave polynomial and two multiply stages.
// Reset (synchronous, active low) restores the register defaults and empties the pipe.
// The result side cannot stall, so the pipe always advances and busy stays low.
module torus_mesh_point_generator
    import tmpg_pkg::*;
(
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [IDX_W-1:0]             i_ring_index,
    input  logic [IDX_W-1:0]             i_step_index,
    output logic                         o_out_strobe,
    output logic signed [COORD_W-1:0]    o_pos_x,
    output logic signed [COORD_W-1:0]    o_pos_y,
    output logic signed [COORD_W-1:0]    o_pos_z,
    output logic [CORNER_W-1:0]          o_corner_a,
    output logic [CORNER_W-1:0]          o_corner_b,
    output logic [CORNER_W-1:0]          o_corner_c,
    output logic [CORNER_W-1:0]          o_corner_d,
    output logic                         o_index_error,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [CFG_DATA_W-1:0]        i_cfg_data
);

    localparam int TR_STAGES = POLY_STEPS + 2;
    localparam int VLD_W     = 1 + (DIV_STEPS + 1) + TR_STAGES + 1;

    // Configuration registers
    logic [RADIUS_W-1:0]   r_major_radius;
    logic [RADIUS_W-1:0]   r_minor_radius;
    logic [SEG_W-1:0]      r_major_segments;
    logic [SEG_W-1:0]      r_minor_segments;
    logic [ANGLE_BITS-1:0] r_start_angle;
    logic [TWIST_W-1:0]    r_twist;

    // Derived segment counts
    logic [SEG_W-1:0]   w_nmaj, w_nmin;
    logic [SEG_W-1:0]   r_nmaj, r_nmin;
    logic [TOTAL_W-1:0] r_total;

    // Pipeline
    logic [VLD_W-1:0]      r_vld;
    logic [IDX_W-1:0]      r_s0_ring, r_s0_step;
    logic [NSUM_W-1:0]     r_s0_nsum;
    logic [CORNER_W-1:0]   r_s0_a, r_s0_base;
    logic                  r_s0_err;
    t_dv_item              r_dv [0:DIV_STEPS];
    t_tr_item              r_tr [0:TR_STAGES-1];
    t_m1_item              r_m1;

    logic [COORD_W-1:0]    r_pos_x, r_pos_y, r_pos_z;
    logic [CORNER_W-1:0]   r_ca, r_cb, r_cc, r_cd;
    logic                  r_err;

    logic                  w_accept;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign w_accept    = start & ~busy;

    // Write configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_major_radius   <= 14'd256;
            r_minor_radius   <= 14'd64;
            r_major_segments <= 9'd48;
            r_minor_segments <= 9'd12;
            r_start_angle    <= '0;
            r_twist          <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_MAJOR_RADIUS:   r_major_radius   <= i_cfg_data[RADIUS_W-1:0];
                CFG_MINOR_RADIUS:   r_minor_radius   <= i_cfg_data[RADIUS_W-1:0];
                CFG_MAJOR_SEGMENTS: r_major_segments <= i_cfg_data[SEG_W-1:0];
                CFG_MINOR_SEGMENTS: r_minor_segments <= i_cfg_data[SEG_W-1:0];
                CFG_START_ANGLE:    r_start_angle    <= i_cfg_data[ANGLE_BITS-1:0];
                CFG_TWIST:          r_twist          <= i_cfg_data[TWIST_W-1:0];
                default: ;
            endcase
        end
    end

    // Clamp segment counts; register copies for the later stages
    assign w_nmaj = clamp_count(r_major_segments, MIN_MAJOR);
    assign w_nmin = clamp_count(r_minor_segments, MIN_MINOR);

    always_ff @(posedge i_clk) begin
        r_nmaj  <= w_nmaj;
        r_nmin  <= w_nmin;
        r_total <= TOTAL_W'(w_nmaj) * TOTAL_W'(w_nmin);
    end

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld        <= '0;
            o_out_strobe <= 1'b0;
        end else begin
            r_vld        <= {r_vld[VLD_W-2:0], w_accept};
            o_out_strobe <= r_vld[VLD_W-1];
        end
    end

    // Capture request: products for the numerator and the linear index
    always_ff @(posedge i_clk) begin
        r_s0_ring <= i_ring_index;
        r_s0_step <= i_step_index;
        r_s0_nsum <= NSUM_W'(i_step_index) * NSUM_W'(w_nmaj)
                   + NSUM_W'(i_ring_index) * NSUM_W'(r_twist);
        r_s0_base <= CORNER_W'(i_ring_index) * CORNER_W'(w_nmin);
        r_s0_a    <= CORNER_W'(i_ring_index) * CORNER_W'(w_nmin) + CORNER_W'(i_step_index);
        r_s0_err  <= ({1'b0, i_ring_index} >= w_nmaj) || ({1'b0, i_step_index} >= w_nmin);
    end

    // Form the corners and load the dividers
    always_ff @(posedge i_clk) begin
        logic                 last;
        logic [TOTAL_W-1:0]   b17, c17, d17;
        t_dv_item             it;
        last = (r_nmin > 9'd2) && ((SEG_W'(r_s0_step) + 9'd1) == r_nmin);
        d17  = last ? TOTAL_W'(r_s0_base) : TOTAL_W'(r_s0_a) + 17'd1;
        b17  = TOTAL_W'(r_s0_a) + TOTAL_W'(r_nmin);
        c17  = d17 + TOTAL_W'(r_nmin);
        it.ring  = r_s0_ring;
        it.nsum  = r_s0_nsum;
        it.a     = r_s0_a;
        it.b     = b17[CORNER_W-1:0];
        it.c     = c17[CORNER_W-1:0];
        it.d     = d17[CORNER_W-1:0];
        it.ge_b  = b17 >= r_total;
        it.ge_c  = c17 >= r_total;
        it.ge_d  = d17 >= r_total;
        it.mb    = REM_W'(b17 - r_total + TOTAL_W'(r_twist));
        it.mc    = REM_W'(c17 - r_total + TOTAL_W'(r_twist));
        it.md    = REM_W'(d17 - r_total + TOTAL_W'(r_twist));
        it.err   = r_s0_err;
        it.phi   = '0;
        it.theta = '0;
        it.qb    = '0;
        it.qc    = '0;
        it.qd    = '0;
        r_dv[0] <= it;
    end

    // Restoring division, one quotient bit per stage in every lane
    for (genvar s = 0; s < DIV_STEPS; s++) begin : g_div
        localparam int BIT = DIV_STEPS - 1 - s;
        logic [DIV_STEPS-1:0] w_phi_dvd, w_theta_dvd, w_b_dvd, w_c_dvd, w_d_dvd;

        assign w_phi_dvd   = DIV_STEPS'({r_dv[s].ring, {ANGLE_BITS{1'b0}}});
        assign w_theta_dvd = {r_dv[s].nsum, {ANGLE_BITS{1'b0}}};
        assign w_b_dvd     = DIV_STEPS'(r_dv[s].mb);
        assign w_c_dvd     = DIV_STEPS'(r_dv[s].mc);
        assign w_d_dvd     = DIV_STEPS'(r_dv[s].md);

        always_ff @(posedge i_clk) begin
            t_dv_item it;
            it       = r_dv[s];
            it.phi   = div_step(r_dv[s].phi, w_phi_dvd[BIT], TOTAL_W'(r_nmaj));
            it.theta = div_step(r_dv[s].theta, w_theta_dvd[BIT], r_total);
            it.qb    = div_step(r_dv[s].qb, w_b_dvd[BIT], TOTAL_W'(r_nmin));
            it.qc    = div_step(r_dv[s].qc, w_c_dvd[BIT], TOTAL_W'(r_nmin));
            it.qd    = div_step(r_dv[s].qd, w_d_dvd[BIT], TOTAL_W'(r_nmin));
            r_dv[s+1] <= it;
        end
    end

    // Pick final corners, fold angles into quarter waves, square the argument
    always_ff @(posedge i_clk) begin
        logic [ANGLE_BITS-1:0] theta, phi;
        logic [ANGLE_BITS-1:0] ang [N_LANES];
        logic [X_W-1:0]        x;
        t_tr_item              it;
        theta = r_dv[DIV_STEPS].theta.quo + r_start_angle;
        phi   = r_dv[DIV_STEPS].phi.quo;
        ang[LANE_SIN_T] = theta;
        ang[LANE_COS_T] = theta + QUARTER_TURN;
        ang[LANE_SIN_P] = phi;
        ang[LANE_COS_P] = phi + QUARTER_TURN;
        for (int l = 0; l < N_LANES; l++) begin
            x = ang[l][FRAC_W] ? X_W'(QUARTER - X_W'(ang[l][FRAC_W-1:0]))
                               : X_W'(ang[l][FRAC_W-1:0]);
            it.lane[l].neg = ang[l][ANGLE_BITS-1];
            it.lane[l].x   = x;
            it.lane[l].x2  = 31'({30'(x) * 30'(x), 2'b00});
            it.lane[l].t   = K9;
            it.lane[l].mag = '0;
        end
        it.a   = r_dv[DIV_STEPS].a;
        it.b   = r_dv[DIV_STEPS].ge_b ? CORNER_W'(r_dv[DIV_STEPS].qb.rem) : r_dv[DIV_STEPS].b;
        it.c   = r_dv[DIV_STEPS].ge_c ? CORNER_W'(r_dv[DIV_STEPS].qc.rem) : r_dv[DIV_STEPS].c;
        it.d   = r_dv[DIV_STEPS].ge_d ? CORNER_W'(r_dv[DIV_STEPS].qd.rem) : r_dv[DIV_STEPS].d;
        it.err = r_dv[DIV_STEPS].err;
        r_tr[0] <= it;
    end

    // Horner steps of the odd polynomial
    for (genvar j = 0; j < POLY_STEPS; j++) begin : g_poly
        always_ff @(posedge i_clk) begin
            t_tr_item it;
            it = r_tr[j];
            for (int l = 0; l < N_LANES; l++) begin
                it.lane[l].t = poly_step(r_tr[j].lane[l].x2, r_tr[j].lane[l].t, POLY_C[j]);
            end
            r_tr[j+1] <= it;
        end
    end

    // Final multiply by the argument, clamp to one
    always_ff @(posedge i_clk) begin
        logic [45:0] p;
        logic [31:0] s;
        t_tr_item    it;
        it = r_tr[POLY_STEPS];
        for (int l = 0; l < N_LANES; l++) begin
            p = 46'(r_tr[POLY_STEPS].lane[l].x) * 46'(r_tr[POLY_STEPS].lane[l].t);
            s = 32'(p >> 14);
            it.lane[l].mag = (s > 32'(Q30_ONE)) ? Q30_ONE : s[30:0];
        end
        r_tr[TR_STAGES-1] <= it;
    end

    // Section circle: radius from the axis and height
    always_ff @(posedge i_clk) begin
        logic [16:0] pc, ps;
        t_tr_item    ti;
        ti = r_tr[TR_STAGES-1];
        pc = mul_round(16'(r_minor_radius), ti.lane[LANE_COS_T].mag);
        ps = mul_round(16'(r_minor_radius), ti.lane[LANE_SIN_T].mag);
        r_m1.r      <= ti.lane[LANE_COS_T].neg ? $signed(17'(r_major_radius) - pc)
                                               : $signed(17'(r_major_radius) + pc);
        r_m1.y      <= ti.lane[LANE_SIN_T].neg ? $signed(17'(0) - ps) : $signed(ps);
        r_m1.mag_sp <= ti.lane[LANE_SIN_P].mag;
        r_m1.mag_cp <= ti.lane[LANE_COS_P].mag;
        r_m1.neg_sp <= ti.lane[LANE_SIN_P].neg;
        r_m1.neg_cp <= ti.lane[LANE_COS_P].neg;
        r_m1.a      <= ti.a;
        r_m1.b      <= ti.b;
        r_m1.c      <= ti.c;
        r_m1.d      <= ti.d;
        r_m1.err    <= ti.err;
    end

    // Sweep about the up axis and saturate
    always_ff @(posedge i_clk) begin
        logic               rneg;
        logic [15:0]        rabs;
        logic [16:0]        px, pz;
        logic signed [17:0] vx, vz;
        rneg = r_m1.r[16];
        rabs = rneg ? 16'(-r_m1.r) : 16'(r_m1.r);
        px   = mul_round(rabs, r_m1.mag_cp);
        pz   = mul_round(rabs, r_m1.mag_sp);
        vx   = (rneg ^ r_m1.neg_cp) ? -$signed({1'b0, px}) : $signed({1'b0, px});
        vz   = (rneg ^ r_m1.neg_sp) ? $signed({1'b0, pz}) : -$signed({1'b0, pz});
        r_pos_x <= sat_coord(vx);
        r_pos_y <= sat_coord(18'(r_m1.y));
        r_pos_z <= sat_coord(vz);
        r_ca    <= r_m1.a;
        r_cb    <= r_m1.b;
        r_cc    <= r_m1.c;
        r_cd    <= r_m1.d;
        r_err   <= r_m1.err;
    end

    assign o_pos_x       = r_pos_x;
    assign o_pos_y       = r_pos_y;
    assign o_pos_z       = r_pos_z;
    assign o_corner_a    = r_ca;
    assign o_corner_b    = r_cb;
    assign o_corner_c    = r_cc;
    assign o_corner_d    = r_cd;
    assign o_index_error = r_err;

endmodule

// ----- sim/tb_top.sv -----
module tb_top;
    import tmpg_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int PIPE_LATENCY = 44;
    localparam int SETTLE_CYCLES = PIPE_LATENCY + 16;
    localparam int STALL_LIMIT = 4000;

    typedef struct {
        logic [COORD_W-1:0]  pos_x;
        logic [COORD_W-1:0]  pos_y;
        logic [COORD_W-1:0]  pos_z;
        logic [CORNER_W-1:0] corner_a;
        logic [CORNER_W-1:0] corner_b;
        logic [CORNER_W-1:0] corner_c;
        logic [CORNER_W-1:0] corner_d;
        logic                index_error;
    } t_vertex_word;

    logic i_clk;
    logic i_rst_n;
    logic start;
    logic busy;
    logic [IDX_W-1:0] i_ring_index;
    logic [IDX_W-1:0] i_step_index;
    logic o_out_strobe;
    logic signed [COORD_W-1:0] o_pos_x, o_pos_y, o_pos_z;
    logic [CORNER_W-1:0] o_corner_a, o_corner_b, o_corner_c, o_corner_d;
    logic o_index_error;
    logic i_cfg_valid;
    logic o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    // Register mirror of the block
    longint unsigned major_r, minor_r, major_segs, minor_segs, start_angle, twist;

    t_vertex_word pending_vertices[$];
    int error_count;
    int quiet_cycles;
    int sender_idle_pct;

    torus_mesh_point_generator uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_ring_index(i_ring_index), .i_step_index(i_step_index),
        .o_out_strobe(o_out_strobe), .o_pos_x(o_pos_x), .o_pos_y(o_pos_y),
        .o_pos_z(o_pos_z), .o_corner_a(o_corner_a), .o_corner_b(o_corner_b),
        .o_corner_c(o_corner_c), .o_corner_d(o_corner_d),
        .o_index_error(o_index_error), .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    initial i_clk = 1'b0;
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic longint unsigned seg_count(longint unsigned v, longint unsigned lo);
        if (v < lo) return lo;
        if (v > 256) return 256;
        return v;
    endfunction

    // sin(pi/2 * x), x and result in Q30
    function automatic longint unsigned quarter_wave(longint unsigned x);
        longint unsigned x2, t, s;
        x2 = (x * x) >> 30;
        t = 64'd5026995 - ((x2 * 64'd172272) >> 30);
        t = 64'd85569306 - ((x2 * t) >> 30);
        t = 64'd693598666 - ((x2 * t) >> 30);
        t = 64'd1686629713 - ((x2 * t) >> 30);
        s = (x * t) >> 30;
        return (s > 64'h4000_0000) ? 64'h4000_0000 : s;
    endfunction

    // Sine of a 32-bit turn fraction, signed Q30
    function automatic longint sine_of_turn(bit [31:0] ang);
        longint unsigned f, m;
        f = ang[29:0];
        m = ang[30] ? quarter_wave(64'h4000_0000 - f) : quarter_wave(f);
        return ang[31] ? -longint'(m) : longint'(m);
    endfunction

    // Product with a Q30 value, rounded half away from zero
    function automatic longint scale_q30(longint r, longint s);
        longint unsigned mr, ms, p;
        bit neg;
        neg = (r < 0) != (s < 0);
        mr = (r < 0) ? -r : r;
        ms = (s < 0) ? -s : s;
        p = (mr * ms + 64'h2000_0000) >> 30;
        return neg ? -longint'(p) : longint'(p);
    endfunction

    function automatic logic [15:0] clip16(longint v);
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return v[15:0];
    endfunction

    function automatic t_vertex_word predict_vertex(longint unsigned ring, longint unsigned step);
        t_vertex_word w;
        longint unsigned nmaj, nmin, total, phi, theta, a, b, c, d;
        longint cos_t, sin_t, cos_p, sin_p, r;
        bit [31:0] th32, ph32;
        nmaj = seg_count(major_segs, 3);
        nmin = seg_count(minor_segs, 2);
        total = nmaj * nmin;
        phi = ((ring << 16) / nmaj) & 64'hFFFF;
        theta = ((((step * nmaj + ring * twist) << 16) / total) + start_angle) & 64'hFFFF;
        th32 = {theta[15:0], 16'h0};
        ph32 = {phi[15:0], 16'h0};
        cos_t = sine_of_turn(th32 + 32'h4000_0000);
        sin_t = sine_of_turn(th32);
        cos_p = sine_of_turn(ph32 + 32'h4000_0000);
        sin_p = sine_of_turn(ph32);
        r = longint'(major_r) + scale_q30(longint'(minor_r), cos_t);
        w.pos_x = clip16(scale_q30(r, cos_p));
        w.pos_y = clip16(scale_q30(longint'(minor_r), sin_t));
        w.pos_z = clip16(-scale_q30(r, sin_p));
        a = ring * nmin + step;
        d = (nmin > 2 && step + 1 == nmin) ? ring * nmin : a + 1;
        b = a + nmin;
        c = d + nmin;
        if (b >= total) b = (b - total + twist) % nmin;
        if (c >= total) c = (c - total + twist) % nmin;
        if (d >= total) d = (d - total + twist) % nmin;
        w.corner_a = a[15:0];
        w.corner_b = b[15:0];
        w.corner_c = c[15:0];
        w.corner_d = d[15:0];
        w.index_error = (ring >= nmaj || step >= nmin);
        return w;
    endfunction

    // Compare each result word against the oldest prediction
    always @(posedge i_clk) begin
        t_vertex_word w;
        if (i_rst_n && o_out_strobe) begin
            if (pending_vertices.size() == 0) begin
                $error("unexpected result word");
                error_count++;
            end else begin
                w = pending_vertices.pop_front();
                if (o_pos_x !== w.pos_x) begin
                    $error("pos_x exp %0h got %0h", w.pos_x, o_pos_x);
                    error_count++;
                end
                if (o_pos_y !== w.pos_y) begin
                    $error("pos_y exp %0h got %0h", w.pos_y, o_pos_y);
                    error_count++;
                end
                if (o_pos_z !== w.pos_z) begin
                    $error("pos_z exp %0h got %0h", w.pos_z, o_pos_z);
                    error_count++;
                end
                if (o_corner_a !== w.corner_a) begin
                    $error("corner_a exp %0d got %0d", w.corner_a, o_corner_a);
                    error_count++;
                end
                if (o_corner_b !== w.corner_b) begin
                    $error("corner_b exp %0d got %0d", w.corner_b, o_corner_b);
                    error_count++;
                end
                if (o_corner_c !== w.corner_c) begin
                    $error("corner_c exp %0d got %0d", w.corner_c, o_corner_c);
                    error_count++;
                end
                if (o_corner_d !== w.corner_d) begin
                    $error("corner_d exp %0d got %0d", w.corner_d, o_corner_d);
                    error_count++;
                end
                if (o_index_error !== w.index_error) begin
                    $error("index_error exp %0b got %0b", w.index_error, o_index_error);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: end the run if no word moves for too long
    always @(posedge i_clk) begin
        if ((start && !busy) || o_out_strobe || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Send one request word and predict its result
    task automatic send_vertex(input logic [IDX_W-1:0] ring, input logic [IDX_W-1:0] step);
        start <= 1'b1;
        i_ring_index <= ring;
        i_step_index <= step;
        do @(posedge i_clk); while (busy);
        pending_vertices.insert(pending_vertices.size(), predict_vertex(ring, step));
        if ($urandom_range(99) < sender_idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    endtask

    // Write one register once the pipe has drained
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        start <= 1'b0;
        wait (pending_vertices.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_MAJOR_RADIUS:   major_r = val & 16'h3FFF;
            CFG_MINOR_RADIUS:   minor_r = val & 16'h3FFF;
            CFG_MAJOR_SEGMENTS: major_segs = val & 16'h1FF;
            CFG_MINOR_SEGMENTS: minor_segs = val & 16'h1FF;
            CFG_START_ANGLE:    start_angle = val;
            CFG_TWIST:          twist = val & 16'h1FF;
            default: ;
        endcase
    endtask

    task automatic set_geometry(input int mr, input int nr, input int nmaj, input int nmin,
                                input int ang, input int tw);
        write_reg(CFG_MAJOR_RADIUS, CFG_DATA_W'(mr));
        write_reg(CFG_MINOR_RADIUS, CFG_DATA_W'(nr));
        write_reg(CFG_MAJOR_SEGMENTS, CFG_DATA_W'(nmaj));
        write_reg(CFG_MINOR_SEGMENTS, CFG_DATA_W'(nmin));
        write_reg(CFG_START_ANGLE, CFG_DATA_W'(ang));
        write_reg(CFG_TWIST, CFG_DATA_W'(tw));
    endtask

    // Corners of the index space plus the wrap and error cases
    task automatic send_corner_cases();
        int nmaj, nmin;
        nmaj = int'(seg_count(major_segs, 3));
        nmin = int'(seg_count(minor_segs, 2));
        send_vertex(IDX_W'(0), IDX_W'(0));
        send_vertex(IDX_W'(nmaj - 1), IDX_W'(nmin - 1));
        send_vertex(IDX_W'(nmaj - 1), IDX_W'(0));
        send_vertex(IDX_W'(0), IDX_W'(nmin - 1));
        send_vertex(IDX_W'(nmaj), IDX_W'(0));
        send_vertex(IDX_W'(0), IDX_W'(nmin));
        send_vertex(IDX_W'(255), IDX_W'(255));
    endtask

    task automatic test_reset_defaults();
        sender_idle_pct = 0;
        send_corner_cases();
    endtask

    task automatic test_extreme_settings();
        // smallest segment counts, zero radii, twist wrap
        set_geometry(0, 0, 3, 2, 0, 1);
        send_corner_cases();
        // largest everything: saturation and full twist
        set_geometry(16'hFFFF, 16'hFFFF, 256, 256, 65535, 256);
        send_corner_cases();
        // out-of-range counts clamp
        set_geometry(12800, 12800, 0, 511, 16384, 511);
        send_corner_cases();
    endtask

    task automatic test_random_phase(input int idle_pct, input int items);
        int nmaj, nmin;
        sender_idle_pct = idle_pct;
        set_geometry($urandom_range(0, 12800), $urandom_range(0, 12800),
                     ($urandom_range(3) == 0) ? $urandom_range(0, 511) : $urandom_range(3, 64),
                     ($urandom_range(3) == 0) ? $urandom_range(0, 511) : $urandom_range(2, 32),
                     $urandom_range(0, 65535), $urandom_range(0, 256));
        nmaj = int'(seg_count(major_segs, 3));
        nmin = int'(seg_count(minor_segs, 2));
        for (int i = 0; i < items; i++) begin
            if ($urandom_range(9) < 8) begin
                send_vertex(IDX_W'($urandom_range(0, nmaj - 1)),
                            IDX_W'($urandom_range(0, nmin - 1)));
            end else begin
                send_vertex(IDX_W'($urandom_range(0, 255)), IDX_W'($urandom_range(0, 255)));
            end
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        start = 1'b0;
        i_ring_index = '0;
        i_step_index = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        error_count = 0;
        quiet_cycles = 0;
        sender_idle_pct = 0;
        major_r = 256;
        minor_r = 64;
        major_segs = 48;
        minor_segs = 12;
        start_angle = 0;
        twist = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_extreme_settings();
        test_random_phase(0, 160);
        test_random_phase(45, 160);
        test_random_phase(11, 160);
        test_random_phase(0, 140);

        start <= 1'b0;
        wait (pending_vertices.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/tmpg_pkg.sv
hdl/torus_mesh_point_generator.sv
sim/tb_top.sv
